// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int FIELD_W     = 32;
  localparam int OP_W        = 4;
  localparam int IN_TDATA_W  = 4 * FIELD_W;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_LT  = 4'd4,
    OP_LE  = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_GE  = 4'd8,
    OP_GT  = 4'd9
  } op_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INF,
    CMD_GCD_DEN,
    CMD_GCD_RES,
    CMD_DIV_Q1,
    CMD_DIV_Q2,
    CMD_DIV_CN,
    CMD_DIV_CD,
    CMD_MUL_AN_BN,
    CMD_MUL_AD_BD,
    CMD_MUL_AN_BD,
    CMD_MUL_AD_BN,
    CMD_MUL_AD_Q1,
    CMD_MUL_AN_Q1,
    CMD_MUL_BN_Q2,
    CMD_ADD,
    CMD_SUB,
    CMD_OUT_ARITH,
    CMD_OUT_CMP,
    CMD_OUT_ZERO
  } cmd_t;

  typedef enum logic [1:0] {
    DST_Q1,
    DST_Q2,
    DST_CN,
    DST_CD
  } dst_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_GCD1,
    S_DIVQ1,
    S_DIVQ2,
    S_M1,
    S_M2,
    S_M3,
    S_SUM,
    S_MUL2M,
    S_MUL2D,
    S_RED,
    S_GCD2,
    S_DIVCN,
    S_DIVCD,
    S_CMP2,
    S_OUT_ARITH,
    S_OUT_CMP,
    S_OUT_ZERO
  } state_t;

  typedef struct packed {
    logic den_zero;
    logic g_one;
    logic gcd_done;
    logic div_done;
    logic out_free;
    op_t  op;
  } stat_t;

endpackage

// ===== hdl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two magnitudes, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int IW = 65
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [IW-1:0] a,
  input  logic [IW-1:0] b,
  output logic          done,
  output logic [IW-1:0] g
);

  localparam int KW = $clog2(IW + 1);

  logic [IW-1:0] u;
  logic [IW-1:0] v;
  logic [KW-1:0] k;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (a == '0 || b == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && u == v) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u <= a;
      v <= b;
      k <= '0;
      if (a == '0 || b == '0) begin
        g <= IW'(1);
      end
    end else if (busy) begin
      if (u == v) begin
        g <= u << k;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end
  end

endmodule

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int IW = 65
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [IW-1:0] n,
  input  logic [IW-1:0] d,
  output logic          done,
  output logic [IW-1:0] q
);

  localparam int KW = $clog2(IW);

  logic [IW:0]   rem;
  logic [IW-1:0] dsr;
  logic [KW-1:0] cnt;
  logic          busy;
  logic [IW:0]   rem_sh;
  logic          take;

  assign rem_sh = {rem[IW-1:0], q[IW-1]};
  assign take   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= n;
      dsr <= d;
      cnt <= KW'(IW - 1);
    end else if (busy) begin
      rem <= take ? rem_sh - {1'b0, dsr} : rem_sh;
      q   <= {q[IW-2:0], take};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== hdl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// Operand, product and result registers with the shared multiplier, gcd unit,
// divider and the output register.
// ----------------------------------------------------------------------------
module rau_datapath #(
  parameter int WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rau_pkg::cmd_t                      cmd,
  output rau_pkg::stat_t                     stat,
  input  logic [rau_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [rau_pkg::OP_W-1:0]           s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rau_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int IW = (2 * WIDTH + 1 > 64) ? 64 : 2 * WIDTH + 1;
  localparam int FW = rau_pkg::FIELD_W;

  rau_pkg::op_t        op;
  rau_pkg::dst_t       div_dst;
  logic signed [WIDTH-1:0] an, ad, bn, bd, q1, q2;
  logic signed [IW-1:0]    cn, cd, tmp;
  logic                    div_neg;

  logic signed [WIDTH-1:0]   ma, mb;
  logic signed [2*WIDTH-1:0] prod;
  logic signed [IW-1:0]      prod_x;

  logic [IW-1:0]        gcd_a, gcd_b, gcd_g, div_n, div_q, div_res;
  logic signed [IW-1:0] div_src;
  logic                 gcd_start, gcd_done, div_start, div_done;

  logic                    inv, truth, fit;
  logic signed [WIDTH-1:0] rn, rd;

  function automatic logic [IW-1:0] mag_f(input logic signed [IW-1:0] x);
    mag_f = x[IW-1] ? (~x + 1'b1) : x;
  endfunction

  always_comb begin
    case (cmd)
      rau_pkg::CMD_MUL_AD_BD: begin ma = ad; mb = bd; end
      rau_pkg::CMD_MUL_AN_BD: begin ma = an; mb = bd; end
      rau_pkg::CMD_MUL_AD_BN: begin ma = ad; mb = bn; end
      rau_pkg::CMD_MUL_AD_Q1: begin ma = ad; mb = q1; end
      rau_pkg::CMD_MUL_AN_Q1: begin ma = an; mb = q1; end
      rau_pkg::CMD_MUL_BN_Q2: begin ma = bn; mb = q2; end
      default:                begin ma = an; mb = bn; end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_x = IW'(prod);

  always_comb begin
    case (cmd)
      rau_pkg::CMD_GCD_DEN: begin
        gcd_a = mag_f(IW'(ad));
        gcd_b = mag_f(IW'(bd));
      end
      default: begin
        gcd_a = mag_f(cd);
        gcd_b = mag_f(cn);
      end
    endcase
    case (cmd)
      rau_pkg::CMD_DIV_Q1: div_src = IW'(bd);
      rau_pkg::CMD_DIV_Q2: div_src = IW'(ad);
      rau_pkg::CMD_DIV_CN: div_src = cn;
      default:             div_src = cd;
    endcase
  end

  assign gcd_start = cmd == rau_pkg::CMD_GCD_DEN || cmd == rau_pkg::CMD_GCD_RES;
  assign div_start = cmd == rau_pkg::CMD_DIV_Q1 || cmd == rau_pkg::CMD_DIV_Q2 ||
                     cmd == rau_pkg::CMD_DIV_CN || cmd == rau_pkg::CMD_DIV_CD;
  assign div_n     = mag_f(div_src);
  assign div_res   = div_neg ? (~div_q + 1'b1) : div_q;

  rau_gcd #(.IW(IW)) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (gcd_a),
    .b     (gcd_b),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div #(.IW(IW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (gcd_g),
    .done  (div_done),
    .q     (div_q)
  );

  assign inv = ad[WIDTH-1] ^ bd[WIDTH-1];

  always_comb begin
    case (op)
      rau_pkg::OP_LT: truth = inv ? (cn > cd)  : (cn < cd);
      rau_pkg::OP_LE: truth = inv ? (cn >= cd) : (cn <= cd);
      rau_pkg::OP_EQ: truth = cn == cd;
      rau_pkg::OP_NE: truth = cn != cd;
      rau_pkg::OP_GE: truth = inv ? (cn <= cd) : (cn >= cd);
      rau_pkg::OP_GT: truth = inv ? (cn < cd)  : (cn > cd);
      default:        truth = 1'b0;
    endcase
  end

  assign fit = (cn[IW-1:WIDTH-1] == {(IW-WIDTH+1){cn[WIDTH-1]}}) &&
               (cd[IW-1:WIDTH-1] == {(IW-WIDTH+1){cd[WIDTH-1]}});
  assign rn  = cn[WIDTH-1:0];
  assign rd  = cd[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd == rau_pkg::CMD_OUT_ARITH || cmd == rau_pkg::CMD_OUT_CMP ||
          cmd == rau_pkg::CMD_OUT_ZERO) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (div_dst)
        rau_pkg::DST_Q1: q1 <= div_res[WIDTH-1:0];
        rau_pkg::DST_Q2: q2 <= div_res[WIDTH-1:0];
        rau_pkg::DST_CN: cn <= div_res;
        default:         cd <= div_res;
      endcase
    end
    case (cmd)
      rau_pkg::CMD_LOAD: begin
        op <= rau_pkg::op_t'(s_tuser);
        an <= s_tdata[0*FW +: WIDTH];
        ad <= s_tdata[1*FW +: WIDTH];
        bn <= s_tdata[2*FW +: WIDTH];
        bd <= s_tdata[3*FW +: WIDTH];
      end
      rau_pkg::CMD_INF: begin
        cn <= IW'(1);
        cd <= '0;
      end
      rau_pkg::CMD_DIV_Q1: begin div_dst <= rau_pkg::DST_Q1; div_neg <= div_src[IW-1]; end
      rau_pkg::CMD_DIV_Q2: begin div_dst <= rau_pkg::DST_Q2; div_neg <= div_src[IW-1]; end
      rau_pkg::CMD_DIV_CN: begin div_dst <= rau_pkg::DST_CN; div_neg <= div_src[IW-1]; end
      rau_pkg::CMD_DIV_CD: begin div_dst <= rau_pkg::DST_CD; div_neg <= div_src[IW-1]; end
      rau_pkg::CMD_MUL_AN_BN: cn  <= prod_x;
      rau_pkg::CMD_MUL_AD_BD: cd  <= prod_x;
      rau_pkg::CMD_MUL_AN_BD: cn  <= prod_x;
      rau_pkg::CMD_MUL_AD_BN: cd  <= prod_x;
      rau_pkg::CMD_MUL_AD_Q1: cd  <= prod_x;
      rau_pkg::CMD_MUL_AN_Q1: cn  <= prod_x;
      rau_pkg::CMD_MUL_BN_Q2: tmp <= prod_x;
      rau_pkg::CMD_ADD:       cn  <= cn + tmp;
      rau_pkg::CMD_SUB:       cn  <= cn - tmp;
      rau_pkg::CMD_OUT_ARITH: m_tdata <= {6'b0, !fit, 1'b0, FW'(rd), FW'(rn)};
      rau_pkg::CMD_OUT_CMP:   m_tdata <= {6'b0, 1'b0, truth, 64'b0};
      rau_pkg::CMD_OUT_ZERO:  m_tdata <= '0;
      default: ;
    endcase
  end

  assign stat.den_zero = ad == '0 || bd == '0;
  assign stat.g_one    = gcd_g == IW'(1);
  assign stat.gcd_done = gcd_done;
  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.op       = op;

endmodule

// ===== hdl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer that steps the datapath through one operation at a time.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  rau_pkg::stat_t stat,
  output rau_pkg::cmd_t  cmd
);

  rau_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = rau_pkg::CMD_NONE;
    s_tready   = 1'b0;
    case (state)
      rau_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd        = rau_pkg::CMD_LOAD;
          state_next = rau_pkg::S_DECODE;
        end
      end
      rau_pkg::S_DECODE: begin
        case (stat.op)
          rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            if (stat.den_zero) begin
              cmd        = rau_pkg::CMD_INF;
              state_next = rau_pkg::S_OUT_ARITH;
            end else begin
              cmd        = rau_pkg::CMD_GCD_DEN;
              state_next = rau_pkg::S_GCD1;
            end
          end
          rau_pkg::OP_MUL: begin
            cmd        = rau_pkg::CMD_MUL_AN_BN;
            state_next = rau_pkg::S_MUL2M;
          end
          rau_pkg::OP_DIV: begin
            cmd        = rau_pkg::CMD_MUL_AN_BD;
            state_next = rau_pkg::S_MUL2D;
          end
          rau_pkg::OP_LT, rau_pkg::OP_LE, rau_pkg::OP_EQ,
          rau_pkg::OP_NE, rau_pkg::OP_GE, rau_pkg::OP_GT: begin
            cmd        = rau_pkg::CMD_MUL_AN_BD;
            state_next = rau_pkg::S_CMP2;
          end
          default: state_next = rau_pkg::S_OUT_ZERO;
        endcase
      end
      rau_pkg::S_GCD1: begin
        if (stat.gcd_done) begin
          cmd        = rau_pkg::CMD_DIV_Q1;
          state_next = rau_pkg::S_DIVQ1;
        end
      end
      rau_pkg::S_DIVQ1: begin
        if (stat.div_done) begin
          cmd        = rau_pkg::CMD_DIV_Q2;
          state_next = rau_pkg::S_DIVQ2;
        end
      end
      rau_pkg::S_DIVQ2: begin
        if (stat.div_done) begin
          state_next = rau_pkg::S_M1;
        end
      end
      rau_pkg::S_M1: begin
        cmd        = rau_pkg::CMD_MUL_AD_Q1;
        state_next = rau_pkg::S_M2;
      end
      rau_pkg::S_M2: begin
        cmd        = rau_pkg::CMD_MUL_AN_Q1;
        state_next = rau_pkg::S_M3;
      end
      rau_pkg::S_M3: begin
        cmd        = rau_pkg::CMD_MUL_BN_Q2;
        state_next = rau_pkg::S_SUM;
      end
      rau_pkg::S_SUM: begin
        cmd        = (stat.op == rau_pkg::OP_SUB) ? rau_pkg::CMD_SUB : rau_pkg::CMD_ADD;
        state_next = rau_pkg::S_RED;
      end
      rau_pkg::S_MUL2M: begin
        cmd        = rau_pkg::CMD_MUL_AD_BD;
        state_next = rau_pkg::S_RED;
      end
      rau_pkg::S_MUL2D: begin
        cmd        = rau_pkg::CMD_MUL_AD_BN;
        state_next = rau_pkg::S_RED;
      end
      rau_pkg::S_RED: begin
        cmd        = rau_pkg::CMD_GCD_RES;
        state_next = rau_pkg::S_GCD2;
      end
      rau_pkg::S_GCD2: begin
        if (stat.gcd_done) begin
          if (stat.g_one) begin
            state_next = rau_pkg::S_OUT_ARITH;
          end else begin
            cmd        = rau_pkg::CMD_DIV_CN;
            state_next = rau_pkg::S_DIVCN;
          end
        end
      end
      rau_pkg::S_DIVCN: begin
        if (stat.div_done) begin
          cmd        = rau_pkg::CMD_DIV_CD;
          state_next = rau_pkg::S_DIVCD;
        end
      end
      rau_pkg::S_DIVCD: begin
        if (stat.div_done) begin
          state_next = rau_pkg::S_OUT_ARITH;
        end
      end
      rau_pkg::S_CMP2: begin
        cmd        = rau_pkg::CMD_MUL_AD_BN;
        state_next = rau_pkg::S_OUT_CMP;
      end
      rau_pkg::S_OUT_ARITH: begin
        if (stat.out_free) begin
          cmd        = rau_pkg::CMD_OUT_ARITH;
          state_next = rau_pkg::S_IDLE;
        end
      end
      rau_pkg::S_OUT_CMP: begin
        if (stat.out_free) begin
          cmd        = rau_pkg::CMD_OUT_CMP;
          state_next = rau_pkg::S_IDLE;
        end
      end
      rau_pkg::S_OUT_ZERO: begin
        if (stat.out_free) begin
          cmd        = rau_pkg::CMD_OUT_ZERO;
          state_next = rau_pkg::S_IDLE;
        end
      end
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational add, sub, mul, div with gcd reduction, and six comparisons.
// ----------------------------------------------------------------------------
// An item on the s channel carries the op code in s_tuser and two fractions
// in s_tdata. Each item gives one item on the m channel: the reduced
// fraction with its overflow flag, the comparison bit, or zeros for an unused op code.
// The block works on one item at a time. Mul and div form two products
// and reduce them with a binary gcd, plus two exact divisions when the gcd
// is not 1. The products and divisions use the intermediate width IW
// (2*WIDTH+1, at most 64). Add and sub add a gcd of the denominators, two
// more divisions, three products and the sum. The gcd unit is bit-serial
// and the divider gives one quotient bit per cycle. The next item is
// accepted the cycle after the result enters the output register.
// Reset clears the sequencer and the output valid. When the receiver stalls
// the finished result waits in the output register and the next item is
// accepted; its result waits for the register to free.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
  parameter int WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // a_num, a_den, b_num, b_den
  input  logic [rau_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op
  input  logic [rau_pkg::OP_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // res_num, res_den, cmp_true, overflow, zero fill
  output logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata
);

  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/sv/rational_arithmetic_unit_core_checker.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_checker
// Watches both channels of the rational unit, predicts and compares results.
// ----------------------------------------------------------------------------
// Every accepted input item is turned into an expected fraction or truth bit
// by an independent model of the unit. Each accepted output item is checked
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rau_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [rau_pkg::OP_W-1:0]        s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              errors,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        cmp_true;
    logic        overflow;
  } frac_res_t;

  frac_res_t expected_q[$];

  function automatic wide_t magnitude(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // Euclid on absolute values; a zero side gives 1.
  function automatic wide_t euclid_gcd(wide_t x, wide_t y);
    wide_t p, q, r;
    p = magnitude(x);
    q = magnitude(y);
    if (p < q) begin
      r = p;
      p = q;
      q = r;
    end
    if (q == 0) return 1;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    return p;
  endfunction

  function automatic logic fits_field(wide_t v);
    return (v >= -(wide_t'(1) <<< 31)) && (v < (wide_t'(1) <<< 31));
  endfunction

  function automatic frac_res_t predict_fraction(logic [rau_pkg::OP_W-1:0] opc,
                                                 logic [rau_pkg::IN_TDATA_W-1:0] d);
    frac_res_t res;
    wide_t an, ad, bn, bd, cn, cd, g, lhs, rhs;
    logic arith, truth, inv;
    an = $signed(d[31:0]);
    ad = $signed(d[63:32]);
    bn = $signed(d[95:64]);
    bd = $signed(d[127:96]);
    lhs = an * bd;
    rhs = ad * bn;
    inv = (ad < 0) != (bd < 0);
    res = '0;
    arith = 1'b0;
    truth = 1'b0;
    cn = 0;
    cd = 0;
    case (opc)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        arith = 1'b1;
        if (ad == 0 || bd == 0) begin
          cn = 1;
          cd = 0;
        end else begin
          cd = ad * (bd / euclid_gcd(ad, bd));
          if (opc == rau_pkg::OP_ADD) cn = an * (cd / ad) + bn * (cd / bd);
          else cn = an * (cd / ad) - bn * (cd / bd);
        end
      end
      rau_pkg::OP_MUL: begin
        arith = 1'b1;
        cn = an * bn;
        cd = ad * bd;
      end
      rau_pkg::OP_DIV: begin
        arith = 1'b1;
        cn = an * bd;
        cd = ad * bn;
      end
      rau_pkg::OP_LT: truth = inv ? (lhs > rhs) : (lhs < rhs);
      rau_pkg::OP_LE: truth = inv ? (lhs >= rhs) : (lhs <= rhs);
      rau_pkg::OP_EQ: truth = (rhs == lhs);
      rau_pkg::OP_NE: truth = (rhs != lhs);
      rau_pkg::OP_GE: truth = inv ? (lhs <= rhs) : (lhs >= rhs);
      rau_pkg::OP_GT: truth = inv ? (lhs < rhs) : (lhs > rhs);
      default: return res;
    endcase
    if (arith) begin
      g = euclid_gcd(cd, cn);
      if (g != 1) begin
        cn = cn / g;
        cd = cd / g;
      end
      res.res_num = cn[31:0];
      res.res_den = cd[31:0];
      res.overflow = !(fits_field(cn) && fits_field(cd));
    end else begin
      res.cmp_true = truth;
    end
    return res;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    frac_res_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_q.push_back(predict_fraction(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expected result: %h", m_tdata);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_tdata[31:0] !== exp_r.res_num) begin
            $error("res_num: expected %h, got %h", exp_r.res_num, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== exp_r.res_den) begin
            $error("res_den: expected %h, got %h", exp_r.res_den, m_tdata[63:32]);
            errors++;
          end
          if (m_tdata[64] !== exp_r.cmp_true) begin
            $error("cmp_true: expected %b, got %b", exp_r.cmp_true, m_tdata[64]);
            errors++;
          end
          if (m_tdata[65] !== exp_r.overflow) begin
            $error("overflow: expected %b, got %b", exp_r.overflow, m_tdata[65]);
            errors++;
          end
        end
      end
      outstanding = expected_q.size();
    end
  end
endmodule

// ===== tb/sv/rational_arithmetic_unit_core_test.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_test
// Stimulus and verdict for the rational arithmetic unit.
// ----------------------------------------------------------------------------
// Sends directed fractions (infinite and zero operands, extremes, overflow,
// mixed-sign denominators, unused op codes) and then random ones, while both
// sides idle at varying rates and the receiver once stalls for a long time.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1880;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [rau_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic [rau_pkg::OP_W-1:0]        s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata;
  int                              errors;
  int                              outstanding;
  int                              tx_idle_pct;
  int                              rx_idle_pct;
  logic                            stall_go;

  rational_arithmetic_unit_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  rational_arithmetic_unit_core_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #200ms;
    $display("rational_arithmetic_unit_core_test failed");
    $finish;
  end

  // Receiver: one long stall on request, otherwise random idling.
  initial begin
    int hold;
    m_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (stall_go && hold == 0 && !rst) hold = 3000;
      if (hold > 1) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        if (hold == 1) hold = -1;
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5, 6: return $urandom_range(0, 60) - 30;
      7: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_fraction(logic [rau_pkg::OP_W-1:0] opc, logic [31:0] an,
                               logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    s_tvalid <= 1'b1;
    s_tuser  <= opc;
    s_tdata  <= {bd, bn, ad, an};
    do @(posedge clk); while (!s_tready);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [rau_pkg::OP_W-1:0] opc;
    opc = ($urandom_range(0, 19) == 0) ? rau_pkg::OP_W'($urandom_range(10, 15))
                                       : rau_pkg::OP_W'($urandom_range(0, 9));
    send_fraction(opc, pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    int i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rau_pkg::OP_ADD;
    stall_go = 1'b0;
    tx_idle_pct = 16;
    rx_idle_pct = 57;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fraction(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(rau_pkg::OP_SUB, 32'd3, 32'd4, 32'd1, 32'd4);
    send_fraction(rau_pkg::OP_ADD, 32'd5, 32'd0, 32'd1, 32'd3);
    send_fraction(rau_pkg::OP_SUB, 32'd1, 32'd3, 32'd7, 32'd0);
    send_fraction(rau_pkg::OP_MUL, 32'd0, 32'd5, 32'd3, 32'd0);
    send_fraction(rau_pkg::OP_DIV, 32'd2, 32'd3, 32'd0, 32'd7);
    send_fraction(rau_pkg::OP_ADD, 32'd0, 32'd5, 32'd0, 32'd5);
    send_fraction(rau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    send_fraction(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);
    send_fraction(rau_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFE);
    send_fraction(rau_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF);
    send_fraction(rau_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd6, 32'd4, 32'hFFFF_FFF7);
    send_fraction(rau_pkg::OP_LT, 32'd1, 32'hFFFF_FFFE, 32'd1, 32'd3);
    send_fraction(rau_pkg::OP_LE, 32'd1, 32'd2, 32'd2, 32'd4);
    send_fraction(rau_pkg::OP_EQ, 32'd1, 32'd2, 32'd2, 32'd4);
    send_fraction(rau_pkg::OP_NE, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(rau_pkg::OP_GE, 32'd5, 32'd3, 32'd1, 32'hFFFF_FFFF);
    send_fraction(rau_pkg::OP_GT, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fraction(rau_pkg::OP_W'(10), 32'd1, 32'd2, 32'd3, 32'd4);
    send_fraction(rau_pkg::OP_W'(15), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);

    stall_go <= 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 20) stall_go <= 1'b0;
      if (i == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 57;
        rx_idle_pct = 16;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random();
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("rational_arithmetic_unit_core_test passed");
    end else begin
      $display("rational_arithmetic_unit_core_test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/rau_pkg.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rau_datapath.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit_core.sv
tb/sv/rational_arithmetic_unit_core_checker.sv
tb/sv/rational_arithmetic_unit_core_test.sv
